// File: rtl/lffa_pkg.sv
// ----------------------------------------------------------------------------
// lffa_pkg
// Shared types, constants and rounding helper for the local frame block.
// ----------------------------------------------------------------------------
package lffa_pkg;

  localparam int unsigned DEFAULT_ANGLE_BITS     = 16;
  localparam int unsigned DEFAULT_COMPONENT_BITS = 16;

  // pi in Q30
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Horner divisors, sine and cosine chains side by side
  localparam int unsigned KS_STEP0 = 42;
  localparam int unsigned KC_STEP0 = 56;
  localparam int unsigned KS_STEP1 = 20;
  localparam int unsigned KC_STEP1 = 30;
  localparam int unsigned KS_STEP2 = 6;
  localparam int unsigned KC_STEP2 = 12;

  typedef enum logic [1:0] {
    REG_X_AXIS = 2'd0,
    REG_Y_AXIS = 2'd1,
    REG_Z_AXIS = 2'd2
  } cfg_reg_t;

  // data carried through the sine/cosine polynomial stages
  typedef struct packed {
    logic        vld;
    logic [29:0] x;
    logic [29:0] x2;
    logic        neg;
    logic [1:0]  q;
    logic [30:0] ts;
    logic [30:0] tc;
  } sc_carry_t;

  // shift right by sh, round to nearest, ties away from zero
  function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
                                                   input int unsigned sh);
    logic [67:0] mag;
    logic [67:0] half;
    half = 68'd1 << (sh - 1);
    mag  = v[67] ? 68'(-v) : 68'(v);
    mag  = (mag + half) >> sh;
    return v[67] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// File: rtl/lffa_hstep.sv
// ----------------------------------------------------------------------------
// lffa_hstep
// One Horner step of both chains: t = 1 - floor(floor(x2*t)/K), three stages.
// ----------------------------------------------------------------------------
module lffa_hstep #(
  parameter int unsigned KS = lffa_pkg::KS_STEP0,
  parameter int unsigned KC = lffa_pkg::KC_STEP0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  lffa_pkg::sc_carry_t  c_in,
  output lffa_pkg::sc_carry_t  c_out
);

  // reciprocal constants: floor(v/K) within one below for v < 2^31
  localparam int unsigned SHS = 31 + $clog2(KS);
  localparam int unsigned SHC = 31 + $clog2(KC);
  localparam logic [31:0] MS  = 32'((64'd1 << SHS) / KS);
  localparam logic [31:0] MC  = 32'((64'd1 << SHC) / KC);

  lffa_pkg::sc_carry_t c1_r, c2_r, c3_r, c3_nxt;
  logic [29:0] ps1_r, pc1_r, ps2_r, pc2_r, qs2_r, qc2_r;
  logic [60:0] ps_full, pc_full;
  logic [61:0] qs_full, qc_full;
  logic [35:0] qs_k, qc_k;
  logic [29:0] qs, qc;

  // stage 1: x2 * t
  assign ps_full = 61'(c_in.x2) * 61'(c_in.ts);
  assign pc_full = 61'(c_in.x2) * 61'(c_in.tc);

  // stage 2: reciprocal estimate
  assign qs_full = 62'(ps1_r) * 62'(MS);
  assign qc_full = 62'(pc1_r) * 62'(MC);

  // stage 3: correct the estimate, form new t
  always_comb begin
    qs_k = 36'(qs2_r) * 36'(KS);
    qc_k = 36'(qc2_r) * 36'(KC);
    qs   = qs2_r;
    qc   = qc2_r;
    if (36'(ps2_r) >= qs_k + 36'(KS)) begin
      qs = qs2_r + 30'd1;
    end
    if (36'(pc2_r) >= qc_k + 36'(KC)) begin
      qc = qc2_r + 30'd1;
    end
    c3_nxt    = c2_r;
    c3_nxt.ts = lffa_pkg::ONE_Q30 - 31'(qs);
    c3_nxt.tc = lffa_pkg::ONE_Q30 - 31'(qc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.vld <= 1'b0;
      c2_r.vld <= 1'b0;
      c3_r.vld <= 1'b0;
    end else if (en) begin
      c1_r <= c_in;
      c2_r <= c1_r;
      c3_r <= c3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps1_r <= ps_full[59:30];
      pc1_r <= pc_full[59:30];
      ps2_r <= ps1_r;
      pc2_r <= pc1_r;
      qs2_r <= 30'(qs_full >> SHS);
      qc2_r <= 30'(qc_full >> SHC);
    end
  end

  assign c_out = c3_r;

endmodule

// File: rtl/lffa_sincos.sv
// ----------------------------------------------------------------------------
// lffa_sincos
// Pipelined sine/cosine of a binary angle, Q30 results, 14 stages.
// ----------------------------------------------------------------------------
module lffa_sincos #(
  parameter int unsigned ANGLE_BITS = lffa_pkg::DEFAULT_ANGLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic                         out_valid,
  output logic signed [31:0]           sn,
  output logic signed [31:0]           cs
);

  localparam int unsigned AB = ANGLE_BITS;

  typedef enum logic [1:0] {Q_POS_X, Q_POS_Y, Q_NEG_X, Q_NEG_Y} quad_t;

  // stage A: quadrant split
  logic [AB-1:0] sum_a, r_a, mag_a;
  logic [1:0]    q_a;
  logic          a_vld_r, a_neg_r;
  logic [1:0]    a_q_r;
  logic [AB-3:0] a_mm_r;

  always_comb begin
    sum_a = angle + (AB'(1) << (AB - 3));
    q_a   = sum_a[AB-1 -: 2];
    r_a   = angle - {q_a, {(AB-2){1'b0}}};
    mag_a = r_a[AB-1] ? -r_a : r_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg_r <= r_a[AB-1];
      a_q_r   <= q_a;
      a_mm_r  <= mag_a[AB-3:0];
    end
  end

  // stage B: residual to radians
  lffa_pkg::sc_carry_t b_nxt, b_r, c_nxt, c_r;
  logic [AB+29:0] xp;
  logic [59:0]    x2p;

  always_comb begin
    xp        = (AB+30)'(a_mm_r) * (AB+30)'(lffa_pkg::PI_Q30);
    b_nxt     = '0;
    b_nxt.vld = a_vld_r;
    b_nxt.x   = 30'(xp >> (AB - 1));
    b_nxt.neg = a_neg_r;
    b_nxt.q   = a_q_r;
  end

  // stage C: square
  always_comb begin
    x2p      = 60'(b_r.x) * 60'(b_r.x);
    c_nxt    = b_r;
    c_nxt.x2 = x2p[59:30];
    c_nxt.ts = lffa_pkg::ONE_Q30;
    c_nxt.tc = lffa_pkg::ONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
      c_r.vld <= 1'b0;
    end else if (en) begin
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  lffa_pkg::sc_carry_t h0, h1, h2;

  lffa_hstep #(.KS(lffa_pkg::KS_STEP0), .KC(lffa_pkg::KC_STEP0)) u_step0 (
    .clk(clk), .rst_n(rst_n), .en(en), .c_in(c_r), .c_out(h0)
  );
  lffa_hstep #(.KS(lffa_pkg::KS_STEP1), .KC(lffa_pkg::KC_STEP1)) u_step1 (
    .clk(clk), .rst_n(rst_n), .en(en), .c_in(h0), .c_out(h1)
  );
  lffa_hstep #(.KS(lffa_pkg::KS_STEP2), .KC(lffa_pkg::KC_STEP2)) u_step2 (
    .clk(clk), .rst_n(rst_n), .en(en), .c_in(h1), .c_out(h2)
  );

  // stage D: last products
  logic [60:0] s_full, pc_full;
  logic        d_vld_r, d_neg_r;
  logic [1:0]  d_q_r;
  logic [29:0] d_s_r;
  logic [30:0] d_c_r;

  assign s_full  = 61'(h2.x) * 61'(h2.ts);
  assign pc_full = 61'(h2.x2) * 61'(h2.tc);

  // stage E: sign and quadrant
  logic signed [31:0] sv, cv, sn_nxt, cs_nxt;
  logic               e_vld_r;
  logic signed [31:0] sn_r, cs_r;

  always_comb begin
    sv = $signed({2'b00, d_s_r});
    if (d_neg_r) begin
      sv = -sv;
    end
    cv = $signed({1'b0, d_c_r});
    case (quad_t'(d_q_r))
      Q_POS_X: begin sn_nxt = sv;  cs_nxt = cv;  end
      Q_POS_Y: begin sn_nxt = cv;  cs_nxt = -sv; end
      Q_NEG_X: begin sn_nxt = -sv; cs_nxt = -cv; end
      default: begin sn_nxt = -cv; cs_nxt = sv;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= h2.vld;
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_neg_r <= h2.neg;
      d_q_r   <= h2.q;
      d_s_r   <= s_full[59:30];
      d_c_r   <= lffa_pkg::ONE_Q30 - 31'(pc_full[59:31]);
      sn_r    <= sn_nxt;
      cs_r    <= cs_nxt;
    end
  end

  assign out_valid = e_vld_r;
  assign sn        = sn_r;
  assign cs        = cs_r;

endmodule

// File: rtl/lffa_combine.sv
// ----------------------------------------------------------------------------
// lffa_combine
// Applies sin/cos of both angles to the frame axes, rounds and saturates.
// ----------------------------------------------------------------------------
module lffa_combine #(
  parameter int unsigned COMPONENT_BITS = lffa_pkg::DEFAULT_COMPONENT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [31:0]            st,
  input  logic signed [31:0]            ct,
  input  logic signed [31:0]            sp,
  input  logic signed [31:0]            cp,
  input  logic [3*COMPONENT_BITS-1:0]   x_axis,
  input  logic [3*COMPONENT_BITS-1:0]   y_axis,
  input  logic [3*COMPONENT_BITS-1:0]   z_axis,
  output logic                          res_valid,
  output logic [9*COMPONENT_BITS-1:0]   res_data
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned F  = CB - 2;
  localparam int unsigned PW = 32 + CB;
  localparam logic signed [67:0] ONE = 68'sd1 <<< F;

  function automatic logic signed [CB-1:0] sat(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v;
    if (v > ONE) begin
      t = ONE;
    end else if (v < -ONE) begin
      t = -ONE;
    end
    return CB'(t);
  endfunction

  logic signed [CB-1:0] xv [3], yv [3], zv [3];

  // result index i uses packed field 2-i (component 0 sits on top)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xv[i] = $signed(x_axis[(2-i)*CB +: CB]);
      yv[i] = $signed(y_axis[(2-i)*CB +: CB]);
      zv[i] = $signed(z_axis[(2-i)*CB +: CB]);
    end
  end

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [31:0] sp1_r, cp1_r, sp2_r, cp2_r;
  logic signed [PW-1:0] pz1_r [3], px1_r [3], pcx1_r [3], psz1_r [3];
  logic signed [33:0]   av2_r [3];
  logic signed [CB-1:0] lx2_r [3], lx3_r [3], lx4_r [3], lx5_r [3];
  logic signed [65:0]   cpa3_r [3], spa3_r [3];
  logic signed [PW-1:0] spy3_r [3], cpy3_r [3];
  logic signed [67:0]   lks4_r [3], lys4_r [3];
  logic signed [CB-1:0] lk5_r [3], ly5_r [3];

  logic signed [33:0]   av_nxt [3];
  logic signed [CB-1:0] lx_nxt [3];
  logic signed [67:0]   lks_nxt [3], lys_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      av_nxt[i]  = 34'(lffa_pkg::rnd_shift(68'(pz1_r[i]) + 68'(px1_r[i]), F));
      lx_nxt[i]  = sat(lffa_pkg::rnd_shift(68'(pcx1_r[i]) - 68'(psz1_r[i]), 30));
      lks_nxt[i] = 68'(cpa3_r[i]) - (68'(spy3_r[i]) <<< (30 - F));
      lys_nxt[i] = (68'(cpy3_r[i]) <<< (30 - F)) + 68'(spa3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp1_r <= sp;
      cp1_r <= cp;
      sp2_r <= sp1_r;
      cp2_r <= cp1_r;
      for (int i = 0; i < 3; i++) begin
        // stage 1: theta products
        pz1_r[i]  <= PW'(ct) * PW'(zv[i]);
        px1_r[i]  <= PW'(st) * PW'(xv[i]);
        pcx1_r[i] <= PW'(ct) * PW'(xv[i]);
        psz1_r[i] <= PW'(st) * PW'(zv[i]);
        // stage 2: A and local x
        av2_r[i]  <= av_nxt[i];
        lx2_r[i]  <= lx_nxt[i];
        // stage 3: phi products
        cpa3_r[i] <= 66'(cp2_r) * 66'(av2_r[i]);
        spa3_r[i] <= 66'(sp2_r) * 66'(av2_r[i]);
        spy3_r[i] <= PW'(sp2_r) * PW'(yv[i]);
        cpy3_r[i] <= PW'(cp2_r) * PW'(yv[i]);
        lx3_r[i]  <= lx2_r[i];
        // stage 4: Q60 sums
        lks4_r[i] <= lks_nxt[i];
        lys4_r[i] <= lys_nxt[i];
        lx4_r[i]  <= lx3_r[i];
        // stage 5: round, saturate
        lk5_r[i]  <= sat(lffa_pkg::rnd_shift(lks4_r[i], 60 - F));
        ly5_r[i]  <= sat(lffa_pkg::rnd_shift(lys4_r[i], 60 - F));
        lx5_r[i]  <= lx4_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_data[i*CB +: CB]     = lk5_r[i];
      res_data[(3+i)*CB +: CB] = lx5_r[i];
      res_data[(6+i)*CB +: CB] = ly5_r[i];
    end
  end

  assign res_valid = v5_r;

endmodule

// File: rtl/local_frame_from_angles_top.sv
// ----------------------------------------------------------------------------
// local_frame_from_angles_top
// Rotates a configured frame by two binary angles; gives look, local x, local y.
// ----------------------------------------------------------------------------
// Takes one angle pair per cycle while the pipe advances and returns one result
// item per pair after 14 stages of sine/cosine (quadrant split,
// radian scaling, squaring, three Horner steps of three stages each with a
// reciprocal-multiply divide, final product, sign/quadrant fix) and 5 stages
// of frame arithmetic (theta products, A and local x, phi products, Q60 sums,
// round and saturate). The whole pipe advances whenever the output register is
// empty or being taken, so a stalled output holds every stage in place.
// Angles wrap modulo one turn (2^ANGLE_BITS units). Components are signed
// fixed point with COMPONENT_BITS-2 fraction bits, saturated to +/-1.0.
// Write frame axes on the cfg port only while no item is in flight; the block
// does not enforce it. Reset frame is the identity for COMPONENT_BITS <= 21.
module local_frame_from_angles_top #(
  parameter int unsigned ANGLE_BITS     = lffa_pkg::DEFAULT_ANGLE_BITS,
  parameter int unsigned COMPONENT_BITS = lffa_pkg::DEFAULT_COMPONENT_BITS,
  localparam int unsigned IN_W  = ((2 * ANGLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((9 * COMPONENT_BITS + 7) / 8) * 8,
  localparam int unsigned RW    = 3 * COMPONENT_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  // input items
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // theta_angle, phi_angle
  // result items
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // look_x, look_y, look_z, local_x_0..2,
                                       // local_y_0..2
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [RW-1:0]    cfg_wdata
);

  localparam int unsigned AB   = ANGLE_BITS;
  localparam int unsigned CB   = COMPONENT_BITS;
  localparam int unsigned F    = CB - 2;
  // axis registers keep at most 64 bits of a write
  localparam int unsigned KEEP = (RW > 64) ? 64 : RW;
  localparam logic [RW-1:0] KEEP_MASK = {RW{1'b1}} >> (RW - KEEP);

  logic [RW-1:0] x_axis_r, y_axis_r, z_axis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_axis_r <= (RW'(1) << (2 * CB + F)) & KEEP_MASK;
      y_axis_r <= (RW'(1) << (CB + F)) & KEEP_MASK;
      z_axis_r <= (RW'(1) << F) & KEEP_MASK;
    end else if (cfg_we) begin
      case (lffa_pkg::cfg_reg_t'(cfg_addr))
        lffa_pkg::REG_X_AXIS: x_axis_r <= cfg_wdata & KEEP_MASK;
        lffa_pkg::REG_Y_AXIS: y_axis_r <= cfg_wdata & KEEP_MASK;
        lffa_pkg::REG_Z_AXIS: z_axis_r <= cfg_wdata & KEEP_MASK;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // global advance: output empty or drained this cycle
  logic en;
  logic res_valid;
  assign en        = !res_valid || out_tready;
  assign in_tready = en;

  logic               vt, vp;
  logic signed [31:0] st, ct, sp, cp;

  lffa_sincos #(.ANGLE_BITS(AB)) u_theta (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .angle($signed(in_tdata[AB-1:0])),
    .out_valid(vt), .sn(st), .cs(ct)
  );

  lffa_sincos #(.ANGLE_BITS(AB)) u_phi (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .angle($signed(in_tdata[2*AB-1:AB])),
    .out_valid(vp), .sn(sp), .cs(cp)
  );

  logic [9*CB-1:0] res_data;

  lffa_combine #(.COMPONENT_BITS(CB)) u_combine (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vt && vp),
    .st(st), .ct(ct), .sp(sp), .cp(cp),
    .x_axis(x_axis_r), .y_axis(y_axis_r), .z_axis(z_axis_r),
    .res_valid(res_valid), .res_data(res_data)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = OUT_W'(res_data);

`ifndef SYNTHESIS
  logic signed [CB-1:0] chk_look_x, chk_local_y_2;
  assign chk_look_x    = $signed(res_data[CB-1:0]);
  assign chk_local_y_2 = $signed(res_data[9*CB-1 -: CB]);

  // both angle pipes stay in lock step
  a_pipes_aligned: assert property (@(posedge clk) disable iff (!rst_n) vt == vp)
    else $error("theta and phi pipes out of step");

  // saturation bound on look_x
  a_look_x_range: assert property (@(posedge clk) disable iff (!rst_n)
      res_valid |-> (chk_look_x <= (CB'(1) <<< F)) && (chk_look_x >= -(CB'(1) <<< F)))
    else $error("look_x beyond +/-1.0");

  a_local_y_range: assert property (@(posedge clk) disable iff (!rst_n)
      res_valid |-> (chk_local_y_2 <= (CB'(1) <<< F)) &&
                    (chk_local_y_2 >= -(CB'(1) <<< F)))
    else $error("local_y_2 beyond +/-1.0");

  // nothing comes out right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
      $past(!rst_n) |-> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule
